[src/tlc_pkg.sv]
// ----------------------------------------------------------------------------
// tlc_pkg: shared types and helpers for the two-way traffic light controller
// Words on the sample and result channels, mode codes, lamp masks, register
// indexes and the small arithmetic helpers used by the step logic and the configuration registers.
// ----------------------------------------------------------------------------
package tlc_pkg;

	localparam int unsigned SECS_W  = 7;
	localparam int unsigned LAMPS_W = 6;
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [SECS_W-1:0] SECS_MIN = 7'd1;
	localparam logic [SECS_W-1:0] SECS_MAX = 7'd99;

	localparam logic [SECS_W-1:0] SOUTH_GREEN_RESET = 7'd15;
	localparam logic [SECS_W-1:0] WEST_GREEN_RESET  = 7'd23;
	localparam logic [SECS_W-1:0] YELLOW_RESET      = 7'd3;

	// register indexes on the configuration channel
	localparam logic [CFG_IDX_W-1:0] CFG_SOUTH_GREEN = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WEST_GREEN  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_YELLOW      = 2'd2;

	// lamp bit positions, west red in bit 0 up to south green in bit 5
	localparam logic [LAMPS_W-1:0] LAMP_RW = 6'b000001;
	localparam logic [LAMPS_W-1:0] LAMP_YW = 6'b000010;
	localparam logic [LAMPS_W-1:0] LAMP_GW = 6'b000100;
	localparam logic [LAMPS_W-1:0] LAMP_RS = 6'b001000;
	localparam logic [LAMPS_W-1:0] LAMP_YS = 6'b010000;
	localparam logic [LAMPS_W-1:0] LAMP_GS = 6'b100000;

	typedef enum logic [2:0] {
		MODE_WAIT    = 3'd0,
		MODE_BEGIN   = 3'd1,
		MODE_RUN     = 3'd2,
		MODE_IDLE    = 3'd3,
		MODE_COUNT   = 3'd4,
		MODE_RELEASE = 3'd5
	} mode_t;

	typedef struct packed {
		logic second_tick;
		logic manual_switch;
		logic change_button;
		logic start_switch;
	} sample_t;

	typedef struct packed {
		logic       west_stop;
		logic       west_yellow;
		logic       west_green;
		logic       south_stop;
		logic       south_yellow;
		logic       south_green;
		logic [7:0] display_bcd;
	} result_t;

	// phase lengths, already clamped to 1..99
	typedef struct packed {
		logic [SECS_W-1:0] south_green_len;
		logic [SECS_W-1:0] west_green_len;
		logic [SECS_W-1:0] yellow_len;
	} cfg_t;

	function automatic logic [SECS_W-1:0] clamp_len(input logic [SECS_W-1:0] v);
		logic [SECS_W-1:0] r;
		if (v < SECS_MIN) r = SECS_MIN;
		else if (v > SECS_MAX) r = SECS_MAX;
		else r = v;
		return r;
	endfunction

	// tens by multiply with 205/2048, exact for every 7-bit value
	function automatic logic [7:0] to_bcd(input logic [SECS_W-1:0] v);
		logic [14:0]       prod;
		logic [3:0]        tens;
		logic [SECS_W-1:0] ones;
		prod = 15'(v) * 15'd205;
		tens = prod[14:11];
		ones = v - 7'(7'(tens) * 7'd10);
		return {tens, ones[3:0]};
	endfunction

	function automatic logic [LAMPS_W-1:0] auto_lamps(
		input logic              phase,
		input logic [SECS_W-1:0] secs,
		input logic [SECS_W-1:0] yellow_len
	);
		logic              yel;
		logic [LAMPS_W-1:0] r;
		yel = (secs <= yellow_len);
		if (!phase) r = LAMP_RW | (yel ? LAMP_YS : LAMP_GS);
		else r = LAMP_RS | (yel ? LAMP_YW : LAMP_GW);
		return r;
	endfunction

endpackage

[src/tlc_core.sv]
// ----------------------------------------------------------------------------
// tlc_core: controller state and one-sample update
// Holds mode, phase, seconds left and lamps; on each step applies one sample
// and drives the result word built from the updated state.
// ----------------------------------------------------------------------------
module tlc_core
	import tlc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    step,
	input  sample_t item,
	input  cfg_t    cfg,
	output result_t res
);

	mode_t              mode_q, mode_d;
	logic               phase_q, phase_d;
	logic [SECS_W-1:0]  secs_q, secs_d;
	logic [LAMPS_W-1:0] lamps_q, lamps_d;

	logic [SECS_W-1:0]  secs_dec;
	logic               phase_nx;
	logic [SECS_W-1:0]  phase_len;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_WAIT;
			phase_q <= 1'b0;
			secs_q  <= '0;
			lamps_q <= '0;
		end else if (step) begin
			mode_q  <= mode_d;
			phase_q <= phase_d;
			secs_q  <= secs_d;
			lamps_q <= lamps_d;
		end
	end

	assign secs_dec = secs_q - 7'd1;

	// the other phase, loaded when a phase ends or manual mode is left
	always_comb begin
		phase_nx = ~phase_q;
		phase_len = phase_nx ? cfg.west_green_len : cfg.south_green_len;
	end

	always_comb begin
		mode_d  = mode_q;
		phase_d = phase_q;
		secs_d  = secs_q;
		lamps_d = lamps_q;
		unique case (mode_q)
			MODE_BEGIN, MODE_RUN: begin
				if (mode_q == MODE_BEGIN && item.manual_switch) begin
					mode_d = MODE_IDLE;
				end else begin
					mode_d = MODE_RUN;
					if (item.second_tick) begin
						if (secs_q > 7'd1) begin
							secs_d  = secs_dec;
							lamps_d = auto_lamps(phase_q, secs_dec, cfg.yellow_len);
							mode_d  = MODE_BEGIN;
						end else begin
							phase_d = phase_nx;
							secs_d  = phase_len;
							lamps_d = auto_lamps(phase_nx, phase_len, cfg.yellow_len);
							mode_d  = MODE_BEGIN;
						end
					end
				end
			end
			MODE_IDLE: begin
				if (!item.manual_switch) begin
					phase_d = phase_nx;
					secs_d  = phase_len;
					lamps_d = auto_lamps(phase_nx, phase_len, cfg.yellow_len);
					mode_d  = MODE_BEGIN;
				end else if (item.change_button) begin
					if ((lamps_q & LAMP_RW) != '0) lamps_d = (lamps_q | LAMP_YS) & ~LAMP_GS;
					else lamps_d = (lamps_q | LAMP_YW) & ~LAMP_GW;
					secs_d = cfg.yellow_len;
					mode_d = MODE_COUNT;
				end
			end
			MODE_COUNT: begin
				if (item.second_tick) begin
					if (secs_q > 7'd1) begin
						secs_d = secs_dec;
					end else begin
						if ((lamps_q & LAMP_RW) != '0) begin
							lamps_d = (lamps_q & ~(LAMP_YS | LAMP_RW)) | LAMP_RS | LAMP_GW;
						end else begin
							lamps_d = (lamps_q & ~(LAMP_YW | LAMP_RS)) | LAMP_RW | LAMP_GS;
						end
						secs_d = '0;
						mode_d = MODE_RELEASE;
					end
				end
			end
			MODE_RELEASE: begin
				if (!item.change_button) mode_d = MODE_IDLE;
			end
			default: begin
				// start always opens the south green phase
				mode_d = MODE_WAIT;
				if (item.start_switch) begin
					phase_d = 1'b0;
					secs_d  = cfg.south_green_len;
					lamps_d = auto_lamps(1'b0, cfg.south_green_len, cfg.yellow_len);
					mode_d  = MODE_BEGIN;
				end
			end
		endcase
	end

	always_comb begin
		res.west_stop    = lamps_d[0];
		res.west_yellow  = lamps_d[1];
		res.west_green   = lamps_d[2];
		res.south_stop   = lamps_d[3];
		res.south_yellow = lamps_d[4];
		res.south_green  = lamps_d[5];
		if (mode_d == MODE_BEGIN || mode_d == MODE_RUN || mode_d == MODE_COUNT) begin
			res.display_bcd = to_bcd(secs_d);
		end else begin
			res.display_bcd = '0;
		end
	end

endmodule

[src/two_way_traffic_light_controller.sv]
// ----------------------------------------------------------------------------
// two_way_traffic_light_controller: west/south lamps with BCD countdown
// Input register, one-pass state update and a result register with
// valid/ready on both sides, plus a small configuration register file.
// ----------------------------------------------------------------------------
// The block takes one sample word per clock while result_ready stays high (tick
// and three switch levels) and returns one result word per sample: six lamp bits
// and a two-digit BCD count. A sample word is held in the input register while
// the state update runs on it, and the result register and the core state load
// together when the step advances; the step stalls while a result word waits to
// be taken, and throughput is one word per cycle as long as result_ready stays
// high. The one-pass state update closing on itself is what sets that
// one-word-per-cycle figure. Configuration words are
// always accepted; write them only while no sample is in flight. Written values
// are clamped to 1..99 as they are stored.
module two_way_traffic_light_controller
	import tlc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 sample_valid,
	output logic                 sample_ready,
	input  sample_t              sample,
	output logic                 result_valid,
	input  logic                 result_ready,
	output result_t              result,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [SECS_W-1:0]    cfg_data
);

	sample_t sample_s1;
	logic    valid_s1;
	logic    advance;
	result_t step_res;
	result_t result_q;
	logic    result_valid_q;
	cfg_t    cfg_q;

	// advance the held sample when the result register is empty or draining
	assign advance      = valid_s1 && (!result_valid_q || result_ready);
	assign sample_ready = !valid_s1 || advance;
	assign cfg_ready    = 1'b1;

	// input register: hold the sample word until the step takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample_ready) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_valid && sample_ready) sample_s1 <= sample;
	end

	// configuration registers, clamped on write; an unknown index is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.south_green_len <= SOUTH_GREEN_RESET;
			cfg_q.west_green_len  <= WEST_GREEN_RESET;
			cfg_q.yellow_len      <= YELLOW_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_SOUTH_GREEN: cfg_q.south_green_len <= clamp_len(cfg_data);
				CFG_WEST_GREEN:  cfg_q.west_green_len  <= clamp_len(cfg_data);
				CFG_YELLOW:      cfg_q.yellow_len      <= clamp_len(cfg_data);
				default: ;
			endcase
		end
	end

	// state update: one sample per advance
	tlc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (sample_s1),
		.cfg    (cfg_q),
		.res    (step_res)
	);

	// result register: load on advance, drop valid once the word is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) result_q <= step_res;
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

`ifndef ASSERT_OFF
	// a side never shows green and yellow together
	a_side_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(result.west_green && result.west_yellow) &&
			!(result.south_green && result.south_yellow))
		else $error("green and yellow lit on one side");

	// both approaches never green at once
	a_no_double_green: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(result.west_green && result.south_green))
		else $error("both approaches green");

	// countdown digits stay decimal
	a_bcd_digits: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.display_bcd[3:0] <= 4'd9) &&
			(result.display_bcd[7:4] <= 4'd9))
		else $error("display is not BCD");

	// a stalled result blocks the step, so the held sample stays pending
	a_stall_holds_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && result_valid_q && !result_ready) |=> valid_s1)
		else $error("sample lost under output stall");
`endif

endmodule

[test/two_way_traffic_light_controller_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_way_traffic_light_controller_tb: lamp and countdown check
// Drives sample words through the controller with random gaps on both
// channels and checks every result word against a cycle-free model of the
// lamps, phase timer and manual change sequence. A short scripted run walks
// start, manual entry, both manual swaps and the return to automatic mode.
// Long random runs follow under several length settings, the clamped
// extremes among them.
// ----------------------------------------------------------------------------
module two_way_traffic_light_controller_tb;
	import tlc_pkg::*;

	// the index past the last register; a write there must change nothing
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
	localparam int PHASES    = 7;
	localparam int PER_PHASE = 90;
	localparam int SCRIPT_N  = 18;

	typedef struct packed {
		sample_t s;
		logic    typed;
		result_t want;
	} script_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 sample_valid;
	logic                 sample_ready;
	sample_t              sample;
	logic                 result_valid;
	logic                 result_ready;
	result_t              result;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [SECS_W-1:0]    cfg_data;

	two_way_traffic_light_controller u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample       (sample),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// model state: raw register values, clamped only where they are used
	logic [SECS_W-1:0]  south_len_reg;
	logic [SECS_W-1:0]  west_len_reg;
	logic [SECS_W-1:0]  yellow_len_reg;
	mode_t              mode_q;
	logic               phase_q;
	logic [SECS_W-1:0]  secs_q;
	logic [LAMPS_W-1:0] lamps_q;

	result_t lights_due[$];
	int      faults;
	bit      calm;
	logic    man_lvl;
	logic    btn_lvl;

	script_row_t script [SCRIPT_N];

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// end the run if the block stops moving words
	initial begin
		#3_000_000;
		$display("two_way_traffic_light_controller_tb: done, errors");
		$finish;
	end

	function automatic logic [SECS_W-1:0] usable_len(input logic [SECS_W-1:0] v);
		if (v == 7'd0) return 7'd1;
		if (v > 7'd99) return 7'd99;
		return v;
	endfunction

	function automatic logic [7:0] bcd_of(input logic [SECS_W-1:0] v);
		logic [SECS_W-1:0] tens;
		logic [SECS_W-1:0] ones;
		tens = v / 7'd10;
		ones = v % 7'd10;
		return {tens[3:0], ones[3:0]};
	endfunction

	// the green side goes yellow once the count is within the yellow time
	function automatic logic [LAMPS_W-1:0] phase_lamps();
		logic yel;
		yel = (secs_q <= usable_len(yellow_len_reg));
		if (!phase_q) return LAMP_RW | (yel ? LAMP_YS : LAMP_GS);
		return LAMP_RS | (yel ? LAMP_YW : LAMP_GW);
	endfunction

	task automatic open_phase(input logic p);
		phase_q = p;
		secs_q  = usable_len(p ? west_len_reg : south_len_reg);
		lamps_q = phase_lamps();
		mode_q  = MODE_BEGIN;
	endtask

	// advance the controller model by one sample and form its result word
	task automatic advance_lights(input sample_t s, output result_t r);
		case (mode_q)
			MODE_BEGIN, MODE_RUN: begin
				// manual is looked at only on the first sample of a second
				if (mode_q == MODE_BEGIN && s.manual_switch) begin
					mode_q = MODE_IDLE;
				end else begin
					mode_q = MODE_RUN;
					if (s.second_tick) begin
						if (secs_q > 7'd1) begin
							secs_q  = secs_q - 7'd1;
							lamps_q = phase_lamps();
							mode_q  = MODE_BEGIN;
						end else begin
							open_phase(~phase_q);
						end
					end
				end
			end
			MODE_IDLE: begin
				if (!s.manual_switch) begin
					open_phase(~phase_q);
				end else if (s.change_button) begin
					// yellow the green side; a tick on this sample is not counted
					if (lamps_q & LAMP_RW) lamps_q = (lamps_q | LAMP_YS) & ~LAMP_GS;
					else lamps_q = (lamps_q | LAMP_YW) & ~LAMP_GW;
					secs_q = usable_len(yellow_len_reg);
					mode_q = MODE_COUNT;
				end
			end
			MODE_COUNT: begin
				if (s.second_tick) begin
					if (secs_q > 7'd1) begin
						secs_q = secs_q - 7'd1;
					end else begin
						// swap the two sides, then hold until the button is let go
						if (lamps_q & LAMP_RW)
							lamps_q = (lamps_q & ~(LAMP_YS | LAMP_RW)) | LAMP_RS | LAMP_GW;
						else
							lamps_q = (lamps_q & ~(LAMP_YW | LAMP_RS)) | LAMP_RW | LAMP_GS;
						secs_q = 7'd0;
						mode_q = MODE_RELEASE;
					end
				end
			end
			MODE_RELEASE: begin
				if (!s.change_button) mode_q = MODE_IDLE;
			end
			default: begin
				mode_q = MODE_WAIT;
				if (s.start_switch) open_phase(1'b0);
			end
		endcase
		r.west_stop    = lamps_q[0];
		r.west_yellow  = lamps_q[1];
		r.west_green   = lamps_q[2];
		r.south_stop   = lamps_q[3];
		r.south_yellow = lamps_q[4];
		r.south_green  = lamps_q[5];
		r.display_bcd  = (mode_q == MODE_BEGIN || mode_q == MODE_RUN || mode_q == MODE_COUNT) ?
			bcd_of(secs_q) : 8'h00;
	endtask

	function automatic bit take_break();
		return !calm && ($urandom_range(99) < 32);
	endfunction

	// mostly held switch levels so manual sequences get far; some pure noise
	function automatic sample_t roll_sample();
		sample_t s;
		if ($urandom_range(99) < 10) begin
			s = sample_t'(4'($urandom_range(15)));
		end else begin
			if ($urandom_range(99) < 6) man_lvl = ~man_lvl;
			if ($urandom_range(99) < 20) btn_lvl = ~btn_lvl;
			s.second_tick   = ($urandom_range(99) < 55);
			s.manual_switch = man_lvl;
			s.change_button = btn_lvl;
			s.start_switch  = ($urandom_range(99) < 15);
		end
		return s;
	endfunction

	// offer one sample word; record its expected result once it is taken
	task automatic push_word(input sample_t s, input logic typed, input result_t want);
		result_t predicted;
		while (take_break()) begin
			sample_valid <= 1'b0;
			@(posedge clk);
		end
		sample_valid <= 1'b1;
		sample       <= s;
		do @(posedge clk); while (!sample_ready);
		advance_lights(s, predicted);
		lights_due.push_back(typed ? want : predicted);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SECS_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_SOUTH_GREEN: south_len_reg  = val;
			CFG_WEST_GREEN:  west_len_reg   = val;
			CFG_YELLOW:      yellow_len_reg = val;
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic load_lengths(input logic [SECS_W-1:0] sg, input logic [SECS_W-1:0] wg,
		input logic [SECS_W-1:0] y);
		write_reg(CFG_SOUTH_GREEN, sg);
		write_reg(CFG_WEST_GREEN, wg);
		write_reg(CFG_YELLOW, y);
	endtask

	// drop valid and wait until every expected word is back
	task automatic settle();
		sample_valid <= 1'b0;
		while (lights_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// check result words in order; stall the result side at random
	always @(posedge clk) begin : watch_results
		result_t want;
		if (result_valid && result_ready) begin
			if (lights_due.size() == 0) begin
				faults++;
				if (faults <= 10)
					$display("%0t: unexpected result word lamps=%b display=%h", $realtime,
						result[13:8], result.display_bcd);
			end else begin
				want = lights_due.pop_front();
				if (result !== want) begin
					faults++;
					if (faults <= 10)
						$display("%0t: lamps (wr..gs) exp %b got %b, display exp %h got %h",
							$realtime, want[13:8], result[13:8], want.display_bcd,
							result.display_bcd);
				end
			end
		end
		result_ready <= calm || ($urandom_range(99) >= 32);
	end

	initial begin : stimulus
		int p;
		int n;
		arst_n       <= 1'b0;
		sample_valid <= 1'b0;
		sample       <= '0;
		result_ready <= 1'b0;
		cfg_valid    <= 1'b0;
		cfg_index    <= CFG_SOUTH_GREEN;
		cfg_data     <= '0;
		faults         = 0;
		calm           = 1'b0;
		man_lvl        = 1'b0;
		btn_lvl        = 1'b0;
		south_len_reg  = SOUTH_GREEN_RESET;
		west_len_reg   = WEST_GREEN_RESET;
		yellow_len_reg = YELLOW_RESET;
		mode_q         = MODE_WAIT;
		phase_q        = 1'b0;
		secs_q         = '0;
		lamps_q        = '0;

		// fields: {tick, manual, button, start}; typed rows carry their own answer
		script = '{
			'{4'b1110, 1'b1, {6'b000000, 8'h00}},  // no start: everything stays dark
			'{4'b0001, 1'b1, {6'b100001, 8'h15}},  // start: south green, west red, 15
			'{4'b1000, 1'b0, '0},  // tick on first sample of a second counts
			'{4'b1100, 1'b0, '0},  // manual entry keeps the lamps, blanks display
			'{4'b1110, 1'b0, '0},  // press: south to yellow, tick not counted
			'{4'b1000, 1'b0, '0},  // manual off during count is ignored
			'{4'b0100, 1'b0, '0},
			'{4'b1000, 1'b0, '0},
			'{4'b1010, 1'b0, '0},  // count ends: west green, south red
			'{4'b0010, 1'b0, '0},  // button still held
			'{4'b0100, 1'b0, '0},  // released, back to manual idle
			'{4'b0110, 1'b0, '0},  // press from the west green side
			'{4'b1100, 1'b0, '0},
			'{4'b1000, 1'b0, '0},
			'{4'b1000, 1'b0, '0},  // swap back to south green
			'{4'b0101, 1'b0, '0},  // release; start is ignored once running
			'{4'b0000, 1'b0, '0},  // leave manual: other phase starts fresh
			'{4'b1001, 1'b0, '0}
		};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (n = 0; n < SCRIPT_N; n++) push_word(script[n].s, script[n].typed, script[n].want);

		for (p = 0; p < PHASES; p++) begin
			if (p != 0) begin
				settle();
				case (p)
					1: load_lengths(7'd1, 7'd1, 7'd1);
					2: load_lengths(7'd0, 7'd127, 7'd0);      // clamp to 1, 99, 1
					3: load_lengths(7'd5, 7'd7, 7'd2);
					4: begin
						load_lengths(7'd100, 7'd3, 7'd99);   // yellow covers the whole phase
						write_reg(CFG_UNUSED, 7'h55);
					end
					5: load_lengths(7'd2, 7'd4, 7'd6);
					default: load_lengths(7'($urandom_range(1, 12)), 7'($urandom_range(1, 12)),
						7'($urandom_range(1, 12)));
				endcase
			end
			// one stretch with both sides streaming at full rate
			calm = (p == 3);
			for (n = 0; n < PER_PHASE; n++) push_word(roll_sample(), 1'b0, '0);
		end
		calm = 1'b0;

		settle();
		repeat (8) @(posedge clk);
		if (faults == 0) begin
			$display("two_way_traffic_light_controller_tb: done, clean");
		end else begin
			$display("two_way_traffic_light_controller_tb: done, errors");
		end
		$finish;
	end

endmodule

[sim.f]
src/tlc_pkg.sv
src/tlc_core.sv
src/two_way_traffic_light_controller.sv
test/two_way_traffic_light_controller_tb.sv
